// ===== rtl/core/hvd_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table of the haversine distance block.
package hvd_pkg;

  localparam int unsigned LANES        = 4;
  localparam int unsigned TURN_W       = 37;
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned ROT_W        = 50;
  localparam int unsigned ANG_W        = 40;
  localparam int unsigned Q31_W        = 33;
  localparam int unsigned SQ_IN_W      = 63;
  localparam int unsigned ROOT_W       = 32;
  localparam int unsigned VEC_W        = 64;
  localparam int unsigned DIST_W       = 29;

  localparam logic [45:0]              PI_Q44         = 46'h3243F6A8885A;
  localparam logic signed [ROT_W-1:0]  CORDIC_X0      = 50'sd85463252869551;
  localparam logic [22:0]              EARTH_RADIUS_M = 23'd6371000;
  localparam logic [SQ_IN_W-1:0]       ONE_Q62        = 63'h4000000000000000;
  localparam logic [DIST_W-1:0]        DIST_MAX       = 29'h1FFFFFFF;

  typedef struct packed {
    logic signed [30:0] start_latitude;
    logic signed [31:0] start_longitude;
    logic signed [30:0] end_latitude;
    logic signed [31:0] end_longitude;
  } pts_t;

  typedef logic [LANES-1:0][TURN_W-1:0] turns_t;

  typedef struct packed {
    logic signed [Q31_W-1:0] c1;
    logic signed [Q31_W-1:0] c2;
    logic signed [Q31_W-1:0] s1;
    logic signed [Q31_W-1:0] s2;
  } trig_t;

  typedef struct packed {
    logic [SQ_IN_W-1:0] a;
    logic [SQ_IN_W-1:0] b;
  } hav_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;
  } roots_t;

  // Arctangent of 2^-i in units of 2^-36 rad.
  function automatic logic signed [ANG_W-1:0] atan_step(int unsigned i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      0:       v = 40'sd53972150818;
      1:       v = 40'sd31861621080;
      2:       v = 40'sd16834805542;
      3:       v = 40'sd8545610155;
      4:       v = 40'sd4289387961;
      5:       v = 40'sd2146785007;
      6:       v = 40'sd1073654455;
      7:       v = 40'sd536859990;
      8:       v = 40'sd268434091;
      9:       v = 40'sd134217557;
      10:      v = 40'sd67108843;
      11:      v = 40'sd33554429;
      12:      v = 40'sd16777216;
      default: v = ANG_W'(1) << (36 - i);
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/hvd_if.sv =====
// Handshake interfaces for the point-pair requests and the distance results.
interface hvd_req_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] start_latitude;
  logic signed [31:0] start_longitude;
  logic signed [30:0] end_latitude;
  logic signed [31:0] end_longitude;

  modport source (output valid, output start_latitude, output start_longitude,
                  output end_latitude, output end_longitude, input ready);
  modport sink   (input valid, input start_latitude, input start_longitude,
                  input end_latitude, input end_longitude, output ready);
endinterface

interface hvd_rsp_if;
  logic        valid;
  logic        ready;
  logic [28:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

// ===== rtl/core/hvd_angle.sv =====
// Degrees to turns: exact rounded division by 360 or 720, two quotient nibbles per stage.
module hvd_angle #(
  parameter int unsigned ANGLE_FRAC_BITS = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  hvd_pkg::pts_t pts_i,
  output logic          vld_o,
  output hvd_pkg::turns_t turn_o
);

  localparam int unsigned TW      = hvd_pkg::TURN_W;
  localparam int unsigned E_LAT   = TW - ANGLE_FRAC_BITS - 3;
  localparam int unsigned E_DIF   = TW - ANGLE_FRAC_BITS - 4;
  localparam int unsigned Y_RAW   = 68 - ANGLE_FRAC_BITS;
  localparam int unsigned NSTG    = (Y_RAW + 7) / 8;
  localparam int unsigned Y_W     = NSTG * 8;
  localparam int unsigned NL      = hvd_pkg::LANES;
  localparam logic [5:0]  DIVISOR = 6'd45;
  localparam logic [4:0]  ROUND_BIAS = 5'd22;

  // One radix-16 long-division step by 45: returns {quotient digit, remainder}.
  function automatic logic [9:0] div45_nib(logic [5:0] r, logic [3:0] nib);
    logic [9:0] t;
    logic [3:0] qd;
    logic [9:0] rem;
    t  = {r, nib};
    qd = '0;
    for (int j = 1; j < 16; j++) begin
      if (t >= 10'(j) * 10'(DIVISOR)) qd = 4'(j);
    end
    rem = t - 10'(qd) * 10'(DIVISOR);
    return {qd, rem[5:0]};
  endfunction

  logic signed [33:0] raw [NL];
  logic [Y_W-1:0]     y_q   [NSTG+1][NL];
  logic [5:0]         r_q   [NSTG+1][NL];
  logic [TW-1:0]      q_q   [NSTG+1][NL];
  logic               neg_q [NSTG+1][NL];
  logic               vld_q [NSTG+1];
  logic               vld_t_q;

  always_comb begin
    raw[0] = 34'(pts_i.start_latitude);
    raw[1] = 34'(pts_i.end_latitude);
    raw[2] = 34'(pts_i.end_latitude) - 34'(pts_i.start_latitude);
    raw[3] = 34'(pts_i.end_longitude) - 34'(pts_i.start_longitude);
  end

  for (genvar l = 0; l < NL; l++) begin : g_in
    localparam int unsigned E = (l < 2) ? E_LAT : E_DIF;
    logic [32:0]    mag;
    logic [Y_W-1:0] y0;
    assign mag = 33'(raw[l][33] ? -raw[l] : raw[l]);
    assign y0  = (Y_W'(mag) << E) + Y_W'(ROUND_BIAS);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[0][l]   <= y0;
        r_q[0][l]   <= '0;
        q_q[0][l]   <= '0;
        neg_q[0][l] <= raw[l][33];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_div
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [7:0] chunk;
      logic [9:0] hi_res;
      logic [9:0] lo_res;
      assign chunk  = y_q[s-1][l][Y_W-1 -: 8];
      assign hi_res = div45_nib(r_q[s-1][l], chunk[7:4]);
      assign lo_res = div45_nib(hi_res[5:0], chunk[3:0]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[s][l]   <= {y_q[s-1][l][Y_W-9:0], 8'h00};
          r_q[s][l]   <= lo_res[5:0];
          q_q[s][l]   <= {q_q[s-1][l][TW-9:0], hi_res[9:6], lo_res[9:6]};
          neg_q[s][l] <= neg_q[s-1][l];
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Apply the sign modulo one turn.
  for (genvar l = 0; l < NL; l++) begin : g_turn
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        turn_o[l] <= neg_q[NSTG][l] ? (TW'(0) - q_q[NSTG][l]) : q_q[NSTG][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t_q <= 1'b0;
    end else if (en_i) begin
      vld_t_q <= vld_q[NSTG];
    end
  end

  assign vld_o = vld_t_q;

endmodule

// ===== rtl/core/hvd_sincos.sv =====
// Four-lane sine/cosine: quarter-turn to radians, pipelined rotation CORDIC, quadrant fold.
module hvd_sincos (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  hvd_pkg::turns_t turn_i,
  output logic            vld_o,
  output hvd_pkg::trig_t  trig_o
);

  localparam int unsigned NL = hvd_pkg::LANES;
  localparam int unsigned NS = hvd_pkg::CORDIC_STEPS;
  localparam int unsigned RW = hvd_pkg::ROT_W;
  localparam int unsigned AW = hvd_pkg::ANG_W;
  localparam int unsigned QW = hvd_pkg::Q31_W;
  localparam logic [22:0] PI_HI = hvd_pkg::PI_Q44[45:23];
  localparam logic [22:0] PI_LO = hvd_pkg::PI_Q44[22:0];
  localparam logic [64:0] RAD_ROUND = 65'd1 << 25;
  localparam logic signed [RW-1:0] Q31_ONE = RW'(1) <<< 31;
  localparam logic signed [RW-1:0] Q31_HALF_LSB = RW'(1) <<< 15;

  function automatic logic signed [QW-1:0] to_q31(logic signed [RW-1:0] v);
    logic signed [RW-1:0] t;
    t = (v + Q31_HALF_LSB) >>> 16;
    if (t > Q31_ONE) t = Q31_ONE;
    if (t < -Q31_ONE) t = -Q31_ONE;
    return QW'(t);
  endfunction

  function automatic logic signed [QW-1:0] fold(logic [1:0] quad, logic signed [QW-1:0] cr,
                                                logic signed [QW-1:0] sr, logic want_sin);
    logic signed [QW-1:0] s;
    logic signed [QW-1:0] c;
    unique case (quad)
      2'd0: begin s = sr;  c = cr;  end
      2'd1: begin s = cr;  c = -sr; end
      2'd2: begin s = -sr; c = -cr; end
      default: begin s = -cr; c = sr; end
    endcase
    return want_sin ? s : c;
  endfunction

  logic [39:0]          pp_hh_q [NL];
  logic [39:0]          pp_hl_q [NL];
  logic [40:0]          pp_lh_q [NL];
  logic [40:0]          pp_ll_q [NL];
  logic [1:0]           quad_a_q [NL];
  logic                 vld_a_q;
  logic signed [RW-1:0] x_q [NS+1][NL];
  logic signed [RW-1:0] y_q [NS+1][NL];
  logic signed [AW-1:0] z_q [NS+1][NL];
  logic [1:0]           quad_q [NS+1][NL];
  logic                 vld_q [NS+1];
  logic signed [QW-1:0] res_q [NL];
  logic                 vld_d_q;

  for (genvar l = 0; l < NL; l++) begin : g_rad
    logic [16:0] rh;
    logic [17:0] rl;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [64:0] sum;
    assign rh  = turn_i[l][34:18];
    assign rl  = turn_i[l][17:0];
    assign hi  = (64'(pp_hh_q[l]) << 23) + 64'(pp_hl_q[l]);
    assign lo  = (64'(pp_lh_q[l]) << 23) + 64'(pp_ll_q[l]);
    assign sum = 65'(hi) + 65'(lo >> 18) + RAD_ROUND;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pp_hh_q[l]  <= 40'(rh) * 40'(PI_HI);
        pp_hl_q[l]  <= 40'(rh) * 40'(PI_LO);
        pp_lh_q[l]  <= 41'(rl) * 41'(PI_HI);
        pp_ll_q[l]  <= 41'(rl) * 41'(PI_LO);
        quad_a_q[l] <= turn_i[l][36:35];
        x_q[0][l]    <= hvd_pkg::CORDIC_X0;
        y_q[0][l]    <= '0;
        z_q[0][l]    <= AW'(sum >> 26);
        quad_q[0][l] <= quad_a_q[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q  <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_a_q  <= vld_i;
      vld_q[0] <= vld_a_q;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_rot
    localparam logic signed [AW-1:0] ATN = hvd_pkg::atan_step(k - 1);
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic signed [RW-1:0] xs;
      logic signed [RW-1:0] ys;
      assign xs = x_q[k-1][l] >>> (k - 1);
      assign ys = y_q[k-1][l] >>> (k - 1);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_q[k-1][l][AW-1]) begin
            x_q[k][l] <= x_q[k-1][l] - ys;
            y_q[k][l] <= y_q[k-1][l] + xs;
            z_q[k][l] <= z_q[k-1][l] - ATN;
          end else begin
            x_q[k][l] <= x_q[k-1][l] + ys;
            y_q[k][l] <= y_q[k-1][l] - xs;
            z_q[k][l] <= z_q[k-1][l] + ATN;
          end
          quad_q[k][l] <= quad_q[k-1][l];
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Lanes 0 and 1 need the cosine, lanes 2 and 3 the sine.
  for (genvar l = 0; l < NL; l++) begin : g_fold
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[l] <= fold(quad_q[NS][l], to_q31(x_q[NS][l]), to_q31(y_q[NS][l]), l >= 2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_d_q <= vld_q[NS];
    end
  end

  assign trig_o.c1 = res_q[0];
  assign trig_o.c2 = res_q[1];
  assign trig_o.s1 = res_q[2];
  assign trig_o.s2 = res_q[3];
  assign vld_o     = vld_d_q;

endmodule

// ===== rtl/core/hvd_haver.sv =====
// Haversine term: products of the trigonometric values, clamp to [0,1] and its complement.
module hvd_haver (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  hvd_pkg::trig_t trig_i,
  output logic           vld_o,
  output hvd_pkg::hav_t  hav_o
);

  localparam int unsigned AW = hvd_pkg::SQ_IN_W;
  localparam logic signed [67:0] HALF_Q31 = 68'sd1073741824;
  localparam logic signed [65:0] ONE_T = 66'(hvd_pkg::ONE_Q62);

  logic signed [65:0] cc_p;
  logic signed [67:0] ts_p;
  logic signed [65:0] t_sum;
  logic signed [33:0] cc_q;
  logic signed [33:0] ts_q;
  logic signed [63:0] s1sq_q1, s1sq_q2, s1sq_q3;
  logic signed [63:0] tss_q;
  logic signed [32:0] s2_q1, s2_q2;
  logic [AW-1:0]      a_q;
  logic [AW-1:0]      a_d;
  logic [4:0]         vld_q;

  assign cc_p  = 66'(trig_i.c1) * 66'(trig_i.c2);
  assign ts_p  = 68'(cc_q) * 68'(s2_q1);
  assign t_sum = 66'(s1sq_q3) + 66'(tss_q);

  always_comb begin
    if (t_sum > ONE_T) begin
      a_d = hvd_pkg::ONE_Q62;
    end else if (t_sum < 66'sd0) begin
      a_d = '0;
    end else begin
      a_d = t_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q    <= 34'((cc_p + 66'(HALF_Q31)) >>> 31);
      s1sq_q1 <= 64'(66'(trig_i.s1) * 66'(trig_i.s1));
      s2_q1   <= trig_i.s2;
      ts_q    <= 34'((ts_p + HALF_Q31) >>> 31);
      s1sq_q2 <= s1sq_q1;
      s2_q2   <= s2_q1;
      tss_q   <= 64'(68'(ts_q) * 68'(s2_q2));
      s1sq_q3 <= s1sq_q2;
      a_q     <= a_d;
      hav_o.a <= a_q;
      hav_o.b <= hvd_pkg::ONE_Q62 - a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  assign vld_o = vld_q[4];

endmodule

// ===== rtl/core/hvd_isqrt.sv =====
// Two-lane floor square root, one result bit per pipeline stage.
module hvd_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  hvd_pkg::hav_t   hav_i,
  output logic            vld_o,
  output hvd_pkg::roots_t roots_o
);

  localparam int unsigned NS = hvd_pkg::ROOT_W;

  logic [63:0] v_q [NS+1][2];
  logic [63:0] r_q [NS+1][2];
  logic        vld_q [NS+1];

  assign v_q[0][0] = 64'(hav_i.a);
  assign v_q[0][1] = 64'(hav_i.b);
  assign r_q[0][0] = '0;
  assign r_q[0][1] = '0;
  assign vld_q[0]  = vld_i;

  for (genvar k = 1; k <= NS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [63:0] trial;
      assign trial = r_q[k-1][l] + BIT;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (v_q[k-1][l] >= trial) begin
            v_q[k][l] <= v_q[k-1][l] - trial;
            r_q[k][l] <= (r_q[k-1][l] >> 1) + BIT;
          end else begin
            v_q[k][l] <= v_q[k-1][l];
            r_q[k][l] <= r_q[k-1][l] >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign roots_o.root_a = r_q[NS][0][NS-1:0];
  assign roots_o.root_b = r_q[NS][1][NS-1:0];
  assign vld_o          = vld_q[NS];

endmodule

// ===== rtl/core/hvd_atan.sv =====
// Central angle by vectoring CORDIC, then scaling by the earth radius with rounding and saturation.
module hvd_atan #(
  parameter int unsigned DIST_FRAC_BITS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  hvd_pkg::roots_t roots_i,
  output logic            vld_o,
  output logic [hvd_pkg::DIST_W-1:0] dist_o
);

  localparam int unsigned NS = hvd_pkg::CORDIC_STEPS;
  localparam int unsigned VW = hvd_pkg::VEC_W;
  localparam int unsigned AW = hvd_pkg::ANG_W;
  localparam int unsigned SH = 35 - DIST_FRAC_BITS;
  localparam logic [61:0] DIST_ROUND = 62'd1 << (SH - 1);

  logic signed [VW-1:0] x_q [NS+1];
  logic signed [VW-1:0] y_q [NS+1];
  logic signed [AW-1:0] z_q [NS+1];
  logic                 vld_q [NS+1];
  logic [37:0]          z_pos;
  logic [60:0]          p_q;
  logic [61:0]          d_round;
  logic                 vld_p_q;
  logic                 vld_r_q;

  assign x_q[0]   = VW'(roots_i.root_b) << 28;
  assign y_q[0]   = VW'(roots_i.root_a) << 28;
  assign z_q[0]   = '0;
  assign vld_q[0] = vld_i;

  for (genvar k = 1; k <= NS; k++) begin : g_vec
    localparam logic signed [AW-1:0] ATN = hvd_pkg::atan_step(k - 1);
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    assign xs = x_q[k-1] >>> (k - 1);
    assign ys = y_q[k-1] >>> (k - 1);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[k-1] > 0) begin
          x_q[k] <= x_q[k-1] + ys;
          y_q[k] <= y_q[k-1] - xs;
          z_q[k] <= z_q[k-1] + ATN;
        end else begin
          x_q[k] <= x_q[k-1] - ys;
          y_q[k] <= y_q[k-1] + xs;
          z_q[k] <= z_q[k-1] - ATN;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // A slightly negative angle from the last iterations counts as zero.
  assign z_pos   = z_q[NS][AW-1] ? '0 : z_q[NS][37:0];
  assign d_round = (62'(p_q) + DIST_ROUND) >> SH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 61'(z_pos) * 61'(hvd_pkg::EARTH_RADIUS_M);
      if (d_round > 62'(hvd_pkg::DIST_MAX)) begin
        dist_o <= hvd_pkg::DIST_MAX;
      end else begin
        dist_o <= d_round[hvd_pkg::DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
      vld_r_q <= 1'b0;
    end else if (en_i) begin
      vld_p_q <= vld_q[NS];
      vld_r_q <= vld_p_q;
    end
  end

  assign vld_o = vld_r_q;

endmodule

// ===== rtl/core/haversine_distance_top.sv =====
// Top level of the fixed-point haversine great-circle distance pipeline.
// The req_i channel takes one item per accepted handshake: two points, each as a
// latitude and longitude in signed degrees with ANGLE_FRAC_BITS fraction bits.
// The rsp_o channel returns, for every item and in the same order, one distance in
// meters with DIST_FRAC_BITS fraction bits, rounded to nearest and saturated.
// Throughput is one item per cycle while rsp_o is not stalled. Each item passes in
// order through the stage chain: the long division of the angles by 360 and 720
// (two quotient nibbles per stage), the 32-stage rotation CORDIC that forms sine
// and cosine, five multiply and clamp stages, the 32-stage square root and the
// 32-stage vectoring CORDIC with the final scaling by the earth radius.
// The whole pipeline advances as one: when the result register holds an item that
// the receiver does not take, every stage holds and req_i.ready drops, so nothing
// is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears only the valid bits; no state is carried between items.
module haversine_distance_top #(
  parameter int unsigned ANGLE_FRAC_BITS = 23,
  parameter int unsigned DIST_FRAC_BITS  = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hvd_req_if.sink      req_i,
  hvd_rsp_if.source    rsp_o
);

  logic            en;
  logic            out_vld;
  hvd_pkg::pts_t   pts;
  logic            ang_vld;
  hvd_pkg::turns_t turns;
  logic            trig_vld;
  hvd_pkg::trig_t  trig;
  logic            hav_vld;
  hvd_pkg::hav_t   hav;
  logic            root_vld;
  hvd_pkg::roots_t roots;
  logic [hvd_pkg::DIST_W-1:0] dist_m;

  // Advance whenever the result register is empty or is being drained.
  assign en          = !out_vld || rsp_o.ready;
  assign req_i.ready = en;

  assign pts.start_latitude  = req_i.start_latitude;
  assign pts.start_longitude = req_i.start_longitude;
  assign pts.end_latitude    = req_i.end_latitude;
  assign pts.end_longitude   = req_i.end_longitude;

  // Angles in degrees become fractions of a turn for both latitudes and the
  // two half differences.
  hvd_angle #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (req_i.valid),
    .pts_i  (pts),
    .vld_o  (ang_vld),
    .turn_o (turns)
  );

  hvd_sincos u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ang_vld),
    .turn_i (turns),
    .vld_o  (trig_vld),
    .trig_o (trig)
  );

  hvd_haver u_haver (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (trig_vld),
    .trig_i (trig),
    .vld_o  (hav_vld),
    .hav_o  (hav)
  );

  hvd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (hav_vld),
    .hav_i   (hav),
    .vld_o   (root_vld),
    .roots_o (roots)
  );

  // The last stage of this unit is the result register seen by rsp_o.
  hvd_atan #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (root_vld),
    .roots_i (roots),
    .vld_o   (out_vld),
    .dist_o  (dist_m)
  );

  assign rsp_o.valid    = out_vld;
  assign rsp_o.distance = dist_m;

endmodule

// ===== tb/haversine_distance_top_tb.sv =====
// Testbench for the haversine distance pipeline: bit-exact prediction, random traffic and stalls.
`timescale 1ns / 100ps

module haversine_distance_top_tb;

  localparam int unsigned ANGLE_FRAC = 23;
  localparam int unsigned DIST_FRAC  = 4;
  localparam longint      ONE_DEG    = 64'sd1 << ANGLE_FRAC;
  localparam longint      LAT_MAX    = 90 * ONE_DEG;
  localparam longint      LON_MAX    = 180 * ONE_DEG;
  localparam int          N_RANDOM   = 900;
  localparam int          CYCLE_LIMIT = 400000;
  // Drain wait after the last owed distance: the pipeline depth plus some slack.
  localparam int          DRAIN_CYCLES = 140;

  // Distance predictor and the queue of distances still owed by the block.
  class distance_scoreboard;
    longint unsigned owed_q[$];
    int              errors;

    function new();
      errors = 0;
    endfunction

    static function longint arctan_unit(int unsigned i);
      longint t[13] = '{64'sd53972150818, 64'sd31861621080, 64'sd16834805542,
                        64'sd8545610155, 64'sd4289387961, 64'sd2146785007,
                        64'sd1073654455, 64'sd536859990, 64'sd268434091,
                        64'sd134217557, 64'sd67108843, 64'sd33554429, 64'sd16777216};
      if (i < 13) return t[i];
      return 64'sd1 << (36 - i);
    endfunction

    // Degrees in fixed point to units of 2^-37 turn, rounded half away from zero.
    static function longint unsigned degrees_to_turns(longint v, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = longint'(v < 0 ? -v : v) << (37 - ANGLE_FRAC);
      q = (mag + den / 2) / den;
      return (v < 0 ? (64'd0 - q) : q) & ((64'd1 << 37) - 1);
    endfunction

    static function longint saturate_q31(longint v);
      longint q;
      q = (v + (64'sd1 << 15)) >>> 16;
      if (q > (64'sd1 << 31)) q = 64'sd1 << 31;
      if (q < -(64'sd1 << 31)) q = -(64'sd1 << 31);
      return q;
    endfunction

    static function void sine_cosine(longint unsigned turns, output longint s,
                                     output longint c);
      longint unsigned r;
      longint unsigned hi;
      longint unsigned lo;
      longint          x;
      longint          y;
      longint          z;
      longint          xs;
      longint          ys;
      longint          cr;
      longint          sr;
      int unsigned     quad;
      quad = (turns >> 35) & 3;
      r = turns & ((64'd1 << 35) - 1);
      hi = (r >> 18) * 64'h3243F6A8885A;
      lo = (r & 64'h3FFFF) * 64'h3243F6A8885A;
      z = longint'((hi + (lo >> 18) + (64'd1 << 25)) >> 26);
      x = 64'sd85463252869551;
      y = 0;
      for (int unsigned i = 0; i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= arctan_unit(i);
        end else begin
          x += ys; y -= xs; z += arctan_unit(i);
        end
      end
      cr = saturate_q31(x);
      sr = saturate_q31(y);
      case (quad)
        0: begin s = sr;  c = cr;  end
        1: begin s = cr;  c = -sr; end
        2: begin s = -sr; c = -cr; end
        default: begin s = -cr; c = sr; end
      endcase
    endfunction

    static function longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function longint unsigned great_circle(longint lat1, longint lon1,
                                                  longint lat2, longint lon2);
      longint          s1, s2, c1, c2, dummy, cc, ts, acc, a, x, y, z, xs, ys;
      longint unsigned p, d;
      longint          one_q62;
      one_q62 = 64'sd1 << 62;
      sine_cosine(degrees_to_turns(lat1, 360), dummy, c1);
      sine_cosine(degrees_to_turns(lat2, 360), dummy, c2);
      sine_cosine(degrees_to_turns(lat2 - lat1, 720), s1, dummy);
      sine_cosine(degrees_to_turns(lon2 - lon1, 720), s2, dummy);
      cc = (c1 * c2 + (64'sd1 << 30)) >>> 31;
      ts = (cc * s2 + (64'sd1 << 30)) >>> 31;
      acc = (s1 * s1 - one_q62) + ts * s2;
      if (acc > 0) a = one_q62;
      else if (acc < -one_q62) a = 0;
      else a = acc + one_q62;
      y = longint'(floor_root(a) << 28);
      x = longint'(floor_root(one_q62 - a) << 28);
      z = 0;
      for (int unsigned i = 0; i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += arctan_unit(i);
        end else begin
          x -= ys; y += xs; z -= arctan_unit(i);
        end
      end
      if (z < 0) z = 0;
      p = longint'(z) * 64'd6371000;
      d = (p + (64'd1 << (34 - DIST_FRAC))) >> (35 - DIST_FRAC);
      if (d > 64'h1FFFFFFF) d = 64'h1FFFFFFF;
      return d;
    endfunction

    function void note_points(longint lat1, longint lon1, longint lat2, longint lon2);
      owed_q = {owed_q, great_circle(lat1, lon1, lat2, lon2)};
    endfunction

    function void check_distance(logic [28:0] got);
      longint unsigned want;
      if (owed_q.size() == 0) begin
        $display("%0t: distance %0d arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got !== want[28:0]) begin
        $display("%0t: distance mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   sent;
  bit   hold_long;

  hvd_req_if req ();
  hvd_rsp_if rsp ();

  distance_scoreboard board = new();

  haversine_distance_top #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC),
    .DIST_FRAC_BITS (DIST_FRAC)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both channels are sampled at the rising edge; the block updates its outputs with
  // nonblocking assignments, so these reads see the values of the handshake itself.
  always @(posedge clk) begin
    if (rst_n && req.valid && req.ready) begin
      board.note_points(longint'(req.start_latitude), longint'(req.start_longitude),
                        longint'(req.end_latitude), longint'(req.end_longitude));
    end
    if (rst_n && rsp.valid && rsp.ready) begin
      board.check_distance(rsp.distance);
    end
  end

  // Watchdog on the total length of the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("haversine_distance_top_tb: errors");
      $finish;
    end
  end

  // Offer one item at the falling edge and hold it until it is taken. Valid stays high
  // into the next call, so back-to-back items keep the input busy every cycle.
  task automatic offer_points(longint lat1, longint lon1, longint lat2, longint lon2);
    @(negedge clk);
    req.valid           = 1'b1;
    req.start_latitude  = lat1[30:0];
    req.start_longitude = lon1[31:0];
    req.end_latitude    = lat2[30:0];
    req.end_longitude   = lon2[31:0];
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      req.valid = 1'b0;
    end
  endtask

  function automatic longint pick_range(longint lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  // A random item: mostly points on the globe, some close pairs for short distances,
  // and some with every bit of the fields free, far beyond the poles and one turn.
  task automatic offer_random();
    longint lat1, lon1, lat2, lon2;
    int     mode;
    mode = $urandom_range(9);
    lat1 = pick_range(LAT_MAX);
    lon1 = pick_range(LON_MAX);
    if (mode < 6) begin
      lat2 = pick_range(LAT_MAX);
      lon2 = pick_range(LON_MAX);
    end else if (mode < 8) begin
      lat2 = lat1 + longint'($urandom_range(1 << 16)) - (1 << 15);
      lon2 = lon1 + longint'($urandom_range(1 << 16)) - (1 << 15);
    end else begin
      lat1 = longint'($signed(31'($urandom())));
      lon1 = longint'($signed($urandom()));
      lat2 = longint'($signed(31'($urandom())));
      lon2 = longint'($signed($urandom()));
    end
    offer_points(lat1, lon1, lat2, lon2);
  endtask

  // The receiver stalls on its own pattern. Once, mid-run, it holds off long enough
  // for the whole pipeline to fill and stop accepting input.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        rsp.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 1'b0;
      end
      stall = $urandom_range(15);
      if (stall < 3) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(6)) @(negedge clk);
      end else if (stall == 3 && sent > 600) begin
        rsp.ready = 1'b1;
        repeat ($urandom_range(60)) @(negedge clk);
      end
      rsp.ready = 1'b1;
    end
  end

  initial begin
    int burst;
    cycles              = 0;
    sent                = 0;
    hold_long           = 1'b0;
    rst_n               = 1'b0;
    req.valid           = 1'b0;
    req.start_latitude  = '0;
    req.start_longitude = '0;
    req.end_latitude    = '0;
    req.end_longitude   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items: identical points, poles, antipodes, wrap at the date line,
    // one-LSB steps and the extreme values of every field.
    offer_points(0, 0, 0, 0);
    offer_points(LAT_MAX, 0, -LAT_MAX, 0);
    offer_points(0, 0, 0, LON_MAX);
    offer_points(0, -LON_MAX, 0, LON_MAX);
    offer_points(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
    offer_points(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    offer_points(0, 0, 1, 0);
    offer_points(0, 0, 0, 1);
    offer_points(45 * ONE_DEG, 7 * ONE_DEG, 45 * ONE_DEG + 1, 7 * ONE_DEG - 1);
    offer_points(LAT_MAX, 0, LAT_MAX, LON_MAX);
    offer_points(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
    offer_points((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
    offer_points(-(64'sd1 << 30), 0, -(64'sd1 << 30), 0);
    offer_points(120 * ONE_DEG, 10 * ONE_DEG, -100 * ONE_DEG, 200 * ONE_DEG);
    offer_points(0, 250 * ONE_DEG, 0, -250 * ONE_DEG);
    offer_points(30 * ONE_DEG, 0, -30 * ONE_DEG, LON_MAX);
    offer_points(-1, -1, 1, 1);

    // Random traffic in bursts with gaps of random length, some with no gap at all.
    while (sent < N_RANDOM + 17) begin
      burst = $urandom_range(40, 1);
      repeat (burst) offer_random();
      if (sent > 300 && sent < 341) hold_long = 1'b1;
      if ($urandom_range(3) != 0) pause_sender($urandom_range(12, 1));
    end
    pause_sender(1);

    while (board.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("haversine_distance_top_tb: clean");
    end else begin
      $display("haversine_distance_top_tb: errors");
    end
    $finish;
  end

endmodule
